>>> design/masked_literal_window_matcher_top_assert.svh
// Assertion macros for the masked literal window matcher.
// Used by masked_literal_window_matcher_top; no other dependencies.
`ifndef MASKED_LITERAL_WINDOW_MATCHER_TOP_ASSERT_SVH
`define MASKED_LITERAL_WINDOW_MATCHER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MLWM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define MLWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define MLWM_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define MLWM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> design/mlwm_pkg.sv
// Shared types and constants for the masked literal window matcher.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mlwm_pkg;

   localparam int DATA_W  = 8;
   localparam int WORD_W  = 64;
   localparam int LEN_W   = 4;
   localparam int ID_W    = 32;
   localparam int END_W   = 32;
   localparam int CSR_W   = 64;
   localparam int ADDR_W  = 6;
   localparam int REG_IDX_W = 3;

   localparam logic [REG_IDX_W-1:0] REG_MATCH_MASK    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_MATCH_COMPARE = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_LITERAL_ID    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_STREAM_MODE   = 3'd4;

   localparam logic [LEN_W-1:0] LEN_RESET = 4'd1;

   typedef struct packed {
      logic [ID_W-1:0]  match_id;
      logic [END_W-1:0] match_end;
   } rsp_entry_type;

endpackage
`default_nettype wire

>>> design/masked_literal_window_matcher_top.sv
// Masked literal window matcher: byte window, masked compare, output skid.
// Depends on mlwm_pkg and masked_literal_window_matcher_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

// One byte is taken per cycle; the window shift and the 64-bit masked compare
// sit between the byte port and a two-entry result buffer, and the byte port
// stalls only when both result entries are full.
// A match reports literal_id and the in-block position of the newest byte.
// Registers sit at byte address 8*index: mask, compare, window length,
// literal id, stream mode. Write them only while the block is idle.
module masked_literal_window_matcher_top #(
   parameter int MAX_WINDOW = 8,
   parameter int POS_BITS   = 32
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  [mlwm_pkg::DATA_W-1:0]        req_data_byte,
   input  wire                                req_first_in_block,
   input  wire                                req_in_scope,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [mlwm_pkg::ID_W-1:0]          rsp_match_id,
   output logic [mlwm_pkg::END_W-1:0]         rsp_match_end,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire  [mlwm_pkg::ADDR_W-1:0]        csr_paddr,
   input  wire  [mlwm_pkg::CSR_W-1:0]         csr_pwdata,
   output logic [mlwm_pkg::CSR_W-1:0]         csr_prdata,
   output logic                               csr_pready
);

   `include "masked_literal_window_matcher_top_assert.svh"

   localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
   localparam int LANE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam logic [mlwm_pkg::LEN_W-1:0] MAX_LEN = mlwm_pkg::LEN_W'(MAX_WINDOW);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WINDOW);

   // configuration
   logic [mlwm_pkg::WORD_W-1:0] mask_ff;
   logic [mlwm_pkg::WORD_W-1:0] compare_ff;
   logic [mlwm_pkg::LEN_W-1:0]  length_ff;
   logic [mlwm_pkg::ID_W-1:0]   literal_id_ff;
   logic                        stream_ff;
   logic                        csr_write;
   logic [mlwm_pkg::REG_IDX_W-1:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[mlwm_pkg::ADDR_W-1:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff       <= '0;
         compare_ff    <= '0;
         length_ff     <= mlwm_pkg::LEN_RESET;
         literal_id_ff <= '0;
         stream_ff     <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            mlwm_pkg::REG_MATCH_MASK:    mask_ff       <= csr_pwdata;
            mlwm_pkg::REG_MATCH_COMPARE: compare_ff    <= csr_pwdata;
            mlwm_pkg::REG_WINDOW_LENGTH: length_ff     <= csr_pwdata[mlwm_pkg::LEN_W-1:0];
            mlwm_pkg::REG_LITERAL_ID:    literal_id_ff <= csr_pwdata[mlwm_pkg::ID_W-1:0];
            mlwm_pkg::REG_STREAM_MODE:   stream_ff     <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         mlwm_pkg::REG_MATCH_MASK:    csr_prdata = mask_ff;
         mlwm_pkg::REG_MATCH_COMPARE: csr_prdata = compare_ff;
         mlwm_pkg::REG_WINDOW_LENGTH:
            csr_prdata = {{(mlwm_pkg::CSR_W-mlwm_pkg::LEN_W){1'b0}}, length_ff};
         mlwm_pkg::REG_LITERAL_ID:
            csr_prdata = {{(mlwm_pkg::CSR_W-mlwm_pkg::ID_W){1'b0}}, literal_id_ff};
         mlwm_pkg::REG_STREAM_MODE:
            csr_prdata = {{(mlwm_pkg::CSR_W-1){1'b0}}, stream_ff};
         default: csr_prdata = '0;
      endcase
   end

   // window and position state
   logic [mlwm_pkg::DATA_W-1:0] hist_ff [MAX_WINDOW];
   logic [mlwm_pkg::DATA_W-1:0] hist_in [MAX_WINDOW];
   logic [CNT_W-1:0]            count_ff, count_in, count_base, count_step;
   logic [POS_BITS-1:0]         pos_ff, pos_in, here;
   logic [mlwm_pkg::LEN_W-1:0]  eff_len, lane_sel;
   logic [mlwm_pkg::WORD_W-1:0] word;
   logic [mlwm_pkg::END_W-1:0]  here_end;
   logic                        req_fire, hit;

   assign req_fire = req_valid && req_ready;

   always_comb begin
      if (length_ff == '0) begin
         eff_len = mlwm_pkg::LEN_W'(1);
      end else if (length_ff > MAX_LEN) begin
         eff_len = MAX_LEN;
      end else begin
         eff_len = length_ff;
      end
   end

   always_comb begin
      here       = req_first_in_block ? '0 : pos_ff;
      pos_in     = here + POS_BITS'(1);
      count_base = (req_first_in_block && !stream_ff) ? '0 : count_ff;
      count_step = (count_base < MAX_CNT) ? count_base + CNT_W'(1) : count_base;
      count_in   = req_in_scope ? count_step : '0;
      hist_in[0] = req_data_byte;
      for (int i = 1; i < MAX_WINDOW; i++) begin
         hist_in[i] = hist_ff[i-1];
      end
      word = '0;
      for (int k = 0; k < MAX_WINDOW; k++) begin
         lane_sel = eff_len - mlwm_pkg::LEN_W'(1) - mlwm_pkg::LEN_W'(k);
         if (mlwm_pkg::LEN_W'(k) < eff_len) begin
            word[8*k +: 8] = hist_in[lane_sel[LANE_W-1:0]];
         end
      end
      hit = req_in_scope && (mlwm_pkg::LEN_W'(count_step) >= eff_len)
            && ((word & mask_ff) == compare_ff);
   end

   generate
      if (POS_BITS >= mlwm_pkg::END_W) begin : g_end_trunc
         assign here_end = here[mlwm_pkg::END_W-1:0];
      end else begin : g_end_ext
         assign here_end = {{(mlwm_pkg::END_W-POS_BITS){1'b0}}, here};
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pos_ff   <= '0;
      end else if (req_fire) begin
         count_ff <= count_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_in_scope) begin
         for (int i = 0; i < MAX_WINDOW; i++) begin
            hist_ff[i] <= hist_in[i];
         end
      end
   end

   // result buffer: output entry plus skid entry
   mlwm_pkg::rsp_entry_type out_ff, skid_ff, new_entry;
   logic out_valid_ff, skid_valid_ff, push, pop;

   assign new_entry.match_id  = literal_id_ff;
   assign new_entry.match_end = here_end;
   assign push      = req_fire && hit;
   assign pop       = out_valid_ff && rsp_ready;
   assign req_ready = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_valid_ff && !pop) begin
         if (push) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (skid_valid_ff) begin
         out_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= push;
      end
   end

   always_ff @(posedge clock) begin
      if (out_valid_ff && !pop) begin
         if (push) begin
            skid_ff <= new_entry;
         end
      end else if (skid_valid_ff) begin
         out_ff <= skid_ff;
      end else if (push) begin
         out_ff <= new_entry;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_match_id  = out_ff.match_id;
   assign rsp_match_end = out_ff.match_end;

   `MLWM_ASSERT_IMPLY(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `MLWM_ASSERT_NEXT(a_scope_clears, clock, reset, req_fire && !req_in_scope, count_ff == '0)
   `MLWM_ASSERT_NEXT(a_block_restart, clock, reset,
      req_fire && req_first_in_block, pos_ff == POS_BITS'(1))
   `MLWM_ASSERT_NEXT(a_block_mode_fill, clock, reset,
      req_fire && req_first_in_block && !stream_ff && req_in_scope, count_ff == CNT_W'(1))

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for masked_literal_window_matcher_top: byte transfers in, matches out.
// Depends on mlwm_pkg; a scoreboard class predicts each match from the current register settings.
`timescale 1ns / 1ps

module testbench;

   localparam int NUM_PHASES      = 16;
   localparam int ITEMS_PER_PHASE = 97;
   localparam int DRAIN_CYCLES    = 16;
   localparam int TIMEOUT_NS      = 3_000_000;

   typedef enum int {MASK_FULL, MASK_FOLD, MASK_RANDOM, MASK_ALL, MASK_NONE, MASK_OUTSIDE}
      mask_kind_type;
   typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_PERIODIC} rx_mode_type;

   class match_scoreboard_type;
      logic [mlwm_pkg::WORD_W-1:0] mask_q;
      logic [mlwm_pkg::WORD_W-1:0] compare_q;
      logic [mlwm_pkg::LEN_W-1:0]  length_q;
      logic [mlwm_pkg::ID_W-1:0]   id_q;
      logic                        stream_q;
      logic [mlwm_pkg::WORD_W-1:0] window;
      int unsigned                 held;
      logic [mlwm_pkg::END_W-1:0]  position;
      mlwm_pkg::rsp_entry_type     expected_matches[$];
      int unsigned                 errors;
      int unsigned                 matches_checked;

      function new();
         mask_q = '0;
         compare_q = '0;
         length_q = mlwm_pkg::LEN_RESET;
         id_q = '0;
         stream_q = 1'b0;
         window = '0;
         held = 0;
         position = '0;
         errors = 0;
         matches_checked = 0;
      endfunction

      function void write_reg(logic [mlwm_pkg::REG_IDX_W-1:0] idx,
                              logic [mlwm_pkg::CSR_W-1:0] value);
         case (idx)
            mlwm_pkg::REG_MATCH_MASK:    mask_q = value;
            mlwm_pkg::REG_MATCH_COMPARE: compare_q = value;
            mlwm_pkg::REG_WINDOW_LENGTH: length_q = value[mlwm_pkg::LEN_W-1:0];
            mlwm_pkg::REG_LITERAL_ID:    id_q = value[mlwm_pkg::ID_W-1:0];
            mlwm_pkg::REG_STREAM_MODE:   stream_q = value[0];
            default: ;
         endcase
      endfunction

      function void note_byte(logic [mlwm_pkg::DATA_W-1:0] value, logic first, logic scope);
         logic [mlwm_pkg::END_W-1:0]  here;
         int unsigned                 span;
         logic [mlwm_pkg::WORD_W-1:0] word;
         mlwm_pkg::rsp_entry_type     hit;
         if (first) begin
            position = '0;
            if (!stream_q) begin
               window = '0;
               held = 0;
            end
         end
         here = position;
         position = position + 1'b1;
         if (!scope) begin
            window = '0;
            held = 0;
            return;
         end
         window = {value, window[mlwm_pkg::WORD_W-1:mlwm_pkg::DATA_W]};
         if (held < 8) held++;
         span = (length_q == 0) ? 1 : ((length_q > 8) ? 8 : length_q);
         if (held >= span) begin
            word = window >> (8 * (8 - span));
            if ((word & mask_q) == compare_q) begin
               hit.match_id = id_q;
               hit.match_end = here;
               expected_matches.push_back(hit);
            end
         end
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_match(logic [mlwm_pkg::ID_W-1:0] id, logic [mlwm_pkg::END_W-1:0] end_pos);
         mlwm_pkg::rsp_entry_type want;
         if (expected_matches.size() == 0) begin
            report($sformatf("unexpected match id %h end %0d", id, end_pos));
            return;
         end
         want = expected_matches.pop_front();
         matches_checked++;
         if (id !== want.match_id)
            report($sformatf("match_id %h, want %h", id, want.match_id));
         if (end_pos !== want.match_end)
            report($sformatf("match_end %0d, want %0d", end_pos, want.match_end));
      endtask

      function int pending();
         return expected_matches.size();
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [mlwm_pkg::DATA_W-1:0]     req_data_byte = '0;
   logic                            req_first_in_block = 1'b0;
   logic                            req_in_scope = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [mlwm_pkg::ID_W-1:0]       rsp_match_id;
   logic [mlwm_pkg::END_W-1:0]      rsp_match_end;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [mlwm_pkg::ADDR_W-1:0]     csr_paddr = '0;
   logic [mlwm_pkg::CSR_W-1:0]      csr_pwdata = '0;
   logic [mlwm_pkg::CSR_W-1:0]      csr_prdata;
   logic                            csr_pready;

   match_scoreboard_type board = new();
   int unsigned          bytes_sent = 0;
   int unsigned          burst_left = 0;
   int unsigned          settings_used = 1;

   masked_literal_window_matcher_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_first_in_block (req_first_in_block),
      .req_in_scope       (req_in_scope),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_match_id       (rsp_match_id),
      .rsp_match_end      (rsp_match_end),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Regression FAIL");
      $finish;
   end

   // receiver: switch at random between stall patterns
   always @(negedge clock) begin : receiver
      static rx_mode_type rx_mode = RX_ALWAYS;
      static int unsigned rx_left = 0;
      static int unsigned rx_phase = 0;
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(16, 96);
      end else begin
         rx_left--;
      end
      rx_phase++;
      case (rx_mode)
         RX_ALWAYS:   rsp_ready <= 1'b1;
         RX_MOSTLY:   rsp_ready <= ($urandom_range(0, 3) != 0);
         RX_RARELY:   rsp_ready <= ($urandom_range(0, 3) == 0);
         RX_PERIODIC: rsp_ready <= (rx_phase % 8 >= 5);
         default:     rsp_ready <= 1'b1;
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_match(rsp_match_id, rsp_match_end);
   end

   task automatic write_reg(input logic [mlwm_pkg::REG_IDX_W-1:0] idx,
                            input logic [mlwm_pkg::CSR_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.write_reg(idx, value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic send_byte(input logic [mlwm_pkg::DATA_W-1:0] value, input logic first,
                            input logic scope);
      int unsigned gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data_byte <= value;
      req_first_in_block <= first;
      req_in_scope <= scope;
      do @(posedge clock); while (!req_ready);
      board.note_byte(value, first, scope);
      bytes_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 40);
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // drop valid, drain every pending match, then let the pipeline empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [mlwm_pkg::LEN_W-1:0]  len_reg;
      int unsigned                 span;
      int unsigned                 pick;
      int unsigned                 cut;
      int unsigned                 done;
      int unsigned                 bit_pos;
      logic [mlwm_pkg::WORD_W-1:0] lit;
      logic [mlwm_pkg::WORD_W-1:0] low;
      logic [mlwm_pkg::WORD_W-1:0] mask_v;
      logic [mlwm_pkg::WORD_W-1:0] compare_v;
      logic [mlwm_pkg::ID_W-1:0]   id_v;
      logic [mlwm_pkg::DATA_W-1:0] lane_mask;
      mask_kind_type               kind;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: one-byte window, empty mask, every in-scope byte matches
      send_byte(8'h00, 1'b1, 1'b1);
      send_byte(8'hFF, 1'b0, 1'b1);
      send_byte(8'h5A, 1'b0, 1'b0);
      send_byte(8'hA5, 1'b0, 1'b1);
      send_byte(8'h3C, 1'b1, 1'b0);
      settle();

      // eight-byte literal split across a block boundary, stream then block mode
      write_reg(mlwm_pkg::REG_MATCH_MASK, '1);
      write_reg(mlwm_pkg::REG_MATCH_COMPARE, 64'h4847_4645_4443_4241);
      write_reg(mlwm_pkg::REG_WINDOW_LENGTH, 64'd8);
      write_reg(mlwm_pkg::REG_LITERAL_ID, 64'hFFFF_FFFF);
      write_reg(mlwm_pkg::REG_STREAM_MODE, 64'd1);
      for (int i = 0; i < 8; i++) send_byte(8'(8'h41 + i), (i == 0 || i == 3), 1'b1);
      settle();
      write_reg(mlwm_pkg::REG_STREAM_MODE, 64'd0);
      for (int i = 0; i < 8; i++) send_byte(8'(8'h41 + i), (i == 0 || i == 3), 1'b1);
      settle();

      // zero length acts as one; out-of-scope byte never matches
      write_reg(mlwm_pkg::REG_MATCH_MASK, 64'hFF);
      write_reg(mlwm_pkg::REG_MATCH_COMPARE, 64'h41);
      write_reg(mlwm_pkg::REG_WINDOW_LENGTH, 64'd0);
      write_reg(mlwm_pkg::REG_LITERAL_ID, 64'd0);
      send_byte(8'h41, 1'b1, 1'b0);
      send_byte(8'h41, 1'b0, 1'b1);
      send_byte(8'h42, 1'b0, 1'b1);
      settings_used += 3;

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         len_reg = p[mlwm_pkg::LEN_W-1:0];
         span = (len_reg == 0) ? 1 : ((len_reg > 8) ? 8 : len_reg);
         low = (span == 8) ? '1 : ((64'd1 << (8 * span)) - 1);
         lit = {$urandom, $urandom};
         kind = mask_kind_type'(p % 6);
         case (kind)
            MASK_FULL:   mask_v = low;
            MASK_FOLD:   mask_v = {8{8'hDF}} & low;
            MASK_RANDOM: mask_v = {$urandom, $urandom};
            MASK_ALL:    mask_v = '1;
            MASK_NONE:   mask_v = '0;
            default:     mask_v = {$urandom, $urandom};
         endcase
         compare_v = lit & mask_v & low;
         if (kind == MASK_OUTSIDE) begin
            bit_pos = $urandom_range(0, mlwm_pkg::WORD_W - 1);
            mask_v[bit_pos] = 1'b0;
            compare_v = (lit & mask_v & low) | (64'd1 << bit_pos);
         end
         id_v = (p == 0) ? '0 : ((p == 1) ? '1 : $urandom);
         write_reg(mlwm_pkg::REG_MATCH_MASK, mask_v);
         write_reg(mlwm_pkg::REG_MATCH_COMPARE, compare_v);
         write_reg(mlwm_pkg::REG_WINDOW_LENGTH, 64'(len_reg));
         write_reg(mlwm_pkg::REG_LITERAL_ID, 64'(id_v));
         write_reg(mlwm_pkg::REG_STREAM_MODE, 64'(p[1]));
         settings_used++;

         done = 0;
         while (done < ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               cut = ($urandom_range(0, 6) == 0) ? $urandom_range(1, span) : span;
               for (int i = 0; i < cut; i++) begin
                  lane_mask = mask_v[8*i +: 8];
                  send_byte((lit[8*i +: 8] & lane_mask) | (8'($urandom) & ~lane_mask),
                            ($urandom_range(0, 19) == 0), 1'b1);
                  done++;
               end
            end else if (pick < 80) begin
               send_byte(8'($urandom), 1'b0, 1'b1);
               done++;
            end else if (pick < 88) begin
               send_byte(8'($urandom), 1'b1, 1'($urandom_range(0, 1)));
               done++;
            end else begin
               send_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
               done++;
            end
         end
      end

      settle();
      $display("Sent %0d bytes under %0d register settings.", bytes_sent, settings_used);
      $display("Checked %0d matches, %0d mismatches.", board.matches_checked, board.errors);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
